// ===== rtl/core/ubhs_pkg.sv =====
// Shared types and constants for the bootloader host sequencer.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none
package ubhs_pkg;

  localparam int MAX_BLOCK = 256;
  localparam int MAX_TX    = 5;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [2:0] OP_CONNECT   = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_GO        = 3'd3;
  localparam logic [2:0] OP_ERASE     = 3'd4;
  localparam logic [2:0] OP_UNPROTECT = 3'd5;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NACK    = 3'd2;
  localparam logic [2:0] ST_BAD     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_UNEXP   = 3'd5;

  localparam logic [7:0] ACK_BYTE   = 8'h79;
  localparam logic [7:0] NACK_BYTE  = 8'h1F;
  localparam logic [7:0] SYNC_BYTE  = 8'h7F;
  localparam logic [7:0] ERASE_ALL  = 8'hFF;

  // One accepted word expands to ntx transmit results, then an optional tail result.
  typedef struct packed {
    logic [2:0]           ntx;
    logic [MAX_TX-1:0][7:0] tx;
    logic                 tail;
    logic                 tail_rv;
    logic [7:0]           tail_rb;
    logic [2:0]           tail_st;
  } desc_t;

  function automatic logic [7:0] cmd_code(input logic [2:0] op);
    logic [7:0] c;
    case (op)
      OP_CONNECT:   c = 8'h7F;
      OP_WRITE:     c = 8'h31;
      OP_READ:      c = 8'h11;
      OP_GO:        c = 8'h21;
      OP_ERASE:     c = 8'h43;
      OP_UNPROTECT: c = 8'h73;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ubhs_front.sv =====
// Front end: accepts input words, runs the protocol state and emits at most one descriptor per word.
// Depends on ubhs_pkg.
`default_nettype none
module ubhs_front
  import ubhs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        acc,
  input  wire logic [1:0]  command,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] address,
  input  wire logic [8:0]  length,
  input  wire logic [7:0]  data_byte,
  output logic             push,
  output desc_t            desc
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ACK_CMD, PH_ACK_ADDR, PH_W_DATA, PH_ACK_LEN, PH_R_DATA,
    PH_ACK_UNP, PH_ACK_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [8:0]  blen_r, blen_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  csum_r, csum_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [15:0] timeout_r;

  logic        awaiting;
  logic [7:0]  lm1, code, axor, csum_new;
  logic [8:0]  rem_dec;
  logic [15:0] timer_inc;

  assign awaiting = (phase_r != PH_IDLE) && (phase_r != PH_W_DATA);
  assign lm1      = 8'(blen_r - 9'd1);
  assign code     = cmd_code(operation);
  assign axor     = addr_r[31:24] ^ addr_r[23:16] ^ addr_r[15:8] ^ addr_r[7:0];
  assign csum_new = csum_r ^ data_byte;
  assign rem_dec  = rem_r - 9'd1;
  assign timer_inc = timer_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    blen_nxt  = blen_r;
    rem_nxt   = rem_r;
    csum_nxt  = csum_r;
    timer_nxt = timer_r;
    desc      = '0;
    push      = 1'b0;
    if (acc) begin
      case (command)
        CMD_BEGIN: begin
          push = 1'b1;
          if (phase_r != PH_IDLE || operation > OP_UNPROTECT) begin
            desc.tail    = 1'b1;
            desc.tail_st = ST_UNEXP;
          end else begin
            op_nxt   = operation;
            addr_nxt = address;
            if (length == 9'd0) begin
              blen_nxt = 9'd1;
            end else if (length > 9'(MAX_BLOCK)) begin
              blen_nxt = 9'(MAX_BLOCK);
            end else begin
              blen_nxt = length;
            end
            csum_nxt  = 8'd0;
            rem_nxt   = 9'd0;
            timer_nxt = 16'd0;
            desc.tx[0] = code;
            if (operation == OP_CONNECT) begin
              desc.ntx  = 3'd1;
              phase_nxt = PH_ACK_DONE;
            end else begin
              desc.tx[1] = ~code;
              desc.ntx   = 3'd2;
              phase_nxt  = PH_ACK_CMD;
            end
          end
        end
        CMD_DATA: begin
          push = 1'b1;
          if (phase_r != PH_W_DATA) begin
            desc.tail    = 1'b1;
            desc.tail_st = ST_UNEXP;
          end else begin
            desc.tx[0] = data_byte;
            desc.ntx   = 3'd1;
            csum_nxt   = csum_new;
            rem_nxt    = rem_dec;
            if (rem_dec == 9'd0) begin
              desc.tx[1] = csum_new;
              desc.ntx   = 3'd2;
              phase_nxt  = PH_ACK_DONE;
              timer_nxt  = 16'd0;
            end
          end
        end
        CMD_RX: begin
          push = 1'b1;
          if (phase_r == PH_R_DATA) begin
            rem_nxt      = rem_dec;
            desc.tail    = 1'b1;
            desc.tail_rv = 1'b1;
            desc.tail_rb = data_byte;
            if (rem_dec == 9'd0) begin
              desc.tail_st = ST_DONE;
              phase_nxt    = PH_IDLE;
            end else begin
              desc.tail_st = ST_BUSY;
            end
          end else if (awaiting) begin
            if (data_byte == ACK_BYTE) begin
              case (phase_r)
                PH_ACK_CMD: begin
                  timer_nxt = 16'd0;
                  if (op_r == OP_ERASE) begin
                    desc.tx[0] = ERASE_ALL;
                    desc.tx[1] = 8'h00;
                    desc.ntx   = 3'd2;
                    phase_nxt  = PH_ACK_DONE;
                  end else if (op_r == OP_UNPROTECT) begin
                    desc.tail    = 1'b1;
                    desc.tail_st = ST_BUSY;
                    phase_nxt    = PH_ACK_UNP;
                  end else begin
                    desc.tx[0] = addr_r[31:24];
                    desc.tx[1] = addr_r[23:16];
                    desc.tx[2] = addr_r[15:8];
                    desc.tx[3] = addr_r[7:0];
                    desc.tx[4] = axor;
                    desc.ntx   = 3'd5;
                    phase_nxt  = PH_ACK_ADDR;
                  end
                end
                PH_ACK_ADDR: begin
                  if (op_r == OP_WRITE) begin
                    desc.tx[0] = lm1;
                    desc.ntx   = 3'd1;
                    csum_nxt   = lm1;
                    rem_nxt    = blen_r;
                    phase_nxt  = PH_W_DATA;
                  end else if (op_r == OP_READ) begin
                    desc.tx[0] = lm1;
                    desc.tx[1] = ~lm1;
                    desc.ntx   = 3'd2;
                    timer_nxt  = 16'd0;
                    phase_nxt  = PH_ACK_LEN;
                  end else begin
                    desc.tail    = 1'b1;
                    desc.tail_st = ST_DONE;
                    phase_nxt    = PH_IDLE;
                  end
                end
                PH_ACK_LEN: begin
                  desc.tail    = 1'b1;
                  desc.tail_st = ST_BUSY;
                  rem_nxt      = blen_r;
                  timer_nxt    = 16'd0;
                  phase_nxt    = PH_R_DATA;
                end
                PH_ACK_UNP: begin
                  desc.tx[0] = SYNC_BYTE;
                  desc.ntx   = 3'd1;
                  timer_nxt  = 16'd0;
                  phase_nxt  = PH_ACK_DONE;
                end
                default: begin
                  desc.tail    = 1'b1;
                  desc.tail_st = ST_DONE;
                  phase_nxt    = PH_IDLE;
                end
              endcase
            end else begin
              desc.tail    = 1'b1;
              desc.tail_st = (data_byte == NACK_BYTE) ? ST_NACK : ST_BAD;
              phase_nxt    = PH_IDLE;
            end
          end else begin
            desc.tail    = 1'b1;
            desc.tail_st = ST_UNEXP;
          end
        end
        CMD_TICK: begin
          if (awaiting) begin
            timer_nxt = timer_inc;
            // timer wrap to zero also counts as expiry
            if (timer_inc >= timeout_r || timer_inc == 16'd0) begin
              push         = 1'b1;
              desc.tail    = 1'b1;
              desc.tail_st = ST_TIMEOUT;
              phase_nxt    = PH_IDLE;
            end
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      op_r      <= 3'd0;
      addr_r    <= 32'd0;
      blen_r    <= 9'd0;
      rem_r     <= 9'd0;
      csum_r    <= 8'd0;
      timer_r   <= 16'd0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      blen_r  <= blen_nxt;
      rem_r   <= rem_nxt;
      csum_r  <= csum_nxt;
      timer_r <= timer_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ubhs_queue.sv =====
// Small flop-based FIFO of descriptors between front and back.
// Depends on ubhs_pkg.
`default_nettype none
module ubhs_queue
  import ubhs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  desc_t      push_desc,
  input  wire logic  pop,
  output desc_t      head,
  output logic       empty,
  output logic       full
);

  desc_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, rptr_r;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ubhs_back.sv =====
// Back end: walks the head descriptor into a registered output stage, one result per cycle
// while that stage is empty or out_ready is high. Depends on ubhs_pkg.
`default_nettype none
module ubhs_back
  import ubhs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  desc_t      head,
  input  wire logic  empty,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic [2:0] status,
  output logic       last
);

  logic [2:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic       txv_r, rv_r, last_r;
  logic [7:0] tx_r, rb_r;
  logic [2:0] st_r;

  logic       load, is_tx, is_last;
  logic [2:0] total;

  assign load    = !empty && (!vld_r || out_ready);
  assign total   = head.ntx + {2'b00, head.tail};
  assign is_tx   = idx_r < head.ntx;
  assign is_last = (idx_r + 3'd1) == total;
  assign pop     = load && is_last;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= is_last;
      if (is_tx) begin
        txv_r <= 1'b1;
        tx_r  <= head.tx[idx_r];
        rv_r  <= 1'b0;
        rb_r  <= 8'd0;
        st_r  <= ST_BUSY;
      end else begin
        txv_r <= 1'b0;
        tx_r  <= 8'd0;
        rv_r  <= head.tail_rv;
        rb_r  <= head.tail_rb;
        st_r  <= head.tail_st;
      end
    end
  end

  assign out_valid  = vld_r;
  assign tx_valid   = txv_r;
  assign tx_byte    = tx_r;
  assign read_valid = rv_r;
  assign read_byte  = rb_r;
  assign status     = st_r;
  assign last       = last_r;

endmodule
`default_nettype wire

// ===== rtl/core/uart_bootloader_host_sequencer_unit.sv =====
// Bootloader host sequencer: front protocol engine, descriptor queue, result serializer.
// An accepted input word's descriptor is registered in the queue, then its first result in the output stage.
// Throughput: one input word per cycle while the queue is not full, into a 4-deep queue; results leave at one
// per cycle while out_tready is high, so a word with N results (1..5) holds the output for N transfers.
// Reset (rst_n low, synchronous): idle phase, empty queue, timeout back to 5000 ticks.
// Depends on ubhs_pkg, ubhs_front, ubhs_queue, ubhs_back.
`default_nettype none
module uart_bootloader_host_sequencer_unit
  import ubhs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,   // timeout_ticks
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,      // operation[2:0], address[34:3], length[43:35],
                                          // data_byte[51:44], zero fill
  input  wire logic [1:0]  in_tuser,      // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,     // tx_byte[7:0], read_byte[15:8], status[18:16], zero fill
  output logic [1:0]       out_tuser,     // tx_valid[0], read_valid[1]
  output logic             out_tlast
);

  desc_t      desc, head;
  logic       push, pop, empty, full, acc;
  logic       txv, rv;
  logic [7:0] txb, rb;
  logic [2:0] st;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  ubhs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .command     (in_tuser),
    .operation   (in_tdata[2:0]),
    .address     (in_tdata[34:3]),
    .length      (in_tdata[43:35]),
    .data_byte   (in_tdata[51:44]),
    .push        (push),
    .desc        (desc)
  );

  ubhs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  ubhs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .tx_valid   (txv),
    .tx_byte    (txb),
    .read_valid (rv),
    .read_byte  (rb),
    .status     (st),
    .last       (out_tlast)
  );

  assign out_tdata = {5'd0, st, rb, txb};
  assign out_tuser = {rv, txv};

endmodule
`default_nettype wire
